/* rtl/touch_angle_to_knob_value_top_macros.svh */
// assertion macros for the touch angle to knob value block
// used by touch_angle_to_knob_value_top, no other dependencies
`ifndef TOUCH_ANGLE_TO_KNOB_VALUE_TOP_MACROS_SVH
`define TOUCH_ANGLE_TO_KNOB_VALUE_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TKV_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define TKV_ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

/* rtl/tkv_pkg.sv */
// shared constants, types and the arctangent table of the knob value block
// no dependencies
package tkv_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned ARC_SPAN_DEG_DEF  = 270;

  // datapath widths
  localparam int unsigned CW        = 9;   // pixel coordinate
  localparam int unsigned XW        = 22;  // cordic x and y
  localparam int unsigned ZW        = 21;  // cordic angle accumulator
  localparam int unsigned AW        = 19;  // wrapped angle in q.10 degrees
  localparam int unsigned VW        = 7;   // knob value
  localparam int unsigned PRE_SHIFT = 8;
  localparam int unsigned DEG_ONE   = 1024;
  localparam int unsigned FULL_TURN = 360 * DEG_ONE;
  localparam int unsigned HALF_TURN = 180 * DEG_ONE;
  localparam int unsigned TABLE_LEN = 24;

  // register reset values
  localparam logic [CW-1:0] CENTER_X_RST  = 9'd240;
  localparam logic [CW-1:0] CENTER_Y_RST  = 9'd240;
  localparam logic [CW-1:0] ARC_START_RST = 9'd135;

  typedef enum logic [1:0] {
    REG_CENTER_X  = 2'd0,
    REG_CENTER_Y  = 2'd1,
    REG_ARC_START = 2'd2
  } reg_idx_e;

  // one cell's worth of cordic data
  typedef struct packed {
    logic                 vld;
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // atan(2^-i) in degrees times 1024, rounded
  function automatic logic [15:0] atan_q10(input int unsigned i);
    logic [15:0] v;
    case (i)
      0:       v = 16'd46080;
      1:       v = 16'd27203;
      2:       v = 16'd14373;
      3:       v = 16'd7296;
      4:       v = 16'd3662;
      5:       v = 16'd1833;
      6:       v = 16'd917;
      7:       v = 16'd458;
      8:       v = 16'd229;
      9:       v = 16'd115;
      10:      v = 16'd57;
      11:      v = 16'd29;
      12:      v = 16'd14;
      13:      v = 16'd7;
      14:      v = 16'd4;
      15:      v = 16'd2;
      16:      v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/tkv_prep.sv */
// front cell: offset from the centre, pre-scale and half-plane fold
// depends on tkv_pkg
module tkv_prep (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic [tkv_pkg::CW-1:0] touch_x_i,
  input  logic [tkv_pkg::CW-1:0] touch_y_i,
  input  logic [tkv_pkg::CW-1:0] center_x_i,
  input  logic [tkv_pkg::CW-1:0] center_y_i,
  output tkv_pkg::cordic_t       cell_o
);
  import tkv_pkg::*;

  logic signed [CW:0]   dx, dy;
  logic signed [XW-1:0] xs, ys;
  cordic_t              cell_d, cell_q;

  always_comb begin
    dx = $signed({1'b0, touch_x_i}) - $signed({1'b0, center_x_i});
    dy = $signed({1'b0, touch_y_i}) - $signed({1'b0, center_y_i});
    xs = XW'(dx) <<< PRE_SHIFT;
    ys = XW'(dy) <<< PRE_SHIFT;
    cell_d.vld  = vld_i;
    cell_d.zero = (dx == '0) && (dy == '0);
    if (dx[CW]) begin
      // left half plane: rotate by 180 degrees
      cell_d.x = -xs;
      cell_d.y = -ys;
      cell_d.z = ZW'(HALF_TURN);
    end else begin
      cell_d.x = xs;
      cell_d.y = ys;
      cell_d.z = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* rtl/tkv_cordic_cell.sv */
// one vectoring cordic iteration with its own register
// depends on tkv_pkg
module tkv_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tkv_pkg::cordic_t cell_i,
  output tkv_pkg::cordic_t cell_o
);
  import tkv_pkg::*;

  localparam logic signed [ZW-1:0] AtanZ = ZW'(atan_q10(STAGE));

  logic signed [XW-1:0] xs, ys;
  cordic_t              cell_d, cell_q;

  always_comb begin
    xs     = cell_i.x >>> STAGE;
    ys     = cell_i.y >>> STAGE;
    cell_d = cell_i;
    if (!cell_i.y[XW-1]) begin
      cell_d.x = cell_i.x + ys;
      cell_d.y = cell_i.y - xs;
      cell_d.z = cell_i.z + AtanZ;
    end else begin
      cell_d.x = cell_i.x - ys;
      cell_d.y = cell_i.y + xs;
      cell_d.z = cell_i.z - AtanZ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

/* rtl/tkv_post.sv */
// angle wrap, arc mapping, dead gap clamp and scaling to percent
// depends on tkv_pkg
module tkv_post #(
  parameter int unsigned ARC_SPAN_DEG = tkv_pkg::ARC_SPAN_DEG_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tkv_pkg::cordic_t       cell_i,
  input  logic [tkv_pkg::CW-1:0] arc_start_i,
  output logic                   vld_o,
  output logic [tkv_pkg::VW-1:0] knob_value_o
);
  import tkv_pkg::*;

  localparam int unsigned NW    = 27;  // rel*200 + span
  localparam int unsigned QW    = 16;  // numerator over 2048
  localparam int unsigned RSH   = 24;  // reciprocal precision
  localparam int unsigned SW    = 9;   // span in degrees
  localparam logic [AW-1:0] SpanQ10 = AW'(ARC_SPAN_DEG * DEG_ONE);
  localparam logic [AW-1:0] FullQ10 = AW'(FULL_TURN);
  localparam logic [SW-1:0] SpanDeg = SW'(ARC_SPAN_DEG);
  localparam logic [RSH:0]  Recip   = (RSH+1)'((64'd1 << RSH) / ARC_SPAN_DEG);
  localparam logic [VW-1:0] MaxVal  = VW'(100);

  logic [5:0] vld_q;

  // p1: wrapped angle
  logic [AW-1:0] ang_d, ang_q;
  // p2: relative to arc start
  logic [CW-1:0] start_adj;
  logic signed [AW:0] rel_s;
  logic [AW-1:0] rel_d, rel_q;
  // p3: dead gap clamp
  logic [AW-1:0] past_end, to_wrap;
  logic [AW-1:0] clp_d, clp_q;
  // p4: rounded numerator over 2048
  logic [NW-1:0] num;
  logic [QW-1:0] quo_d, quo_q, quo2_q;
  // p5: reciprocal estimate
  logic [QW+RSH:0] prod;
  logic [VW-1:0]   est_d, est_q;
  // p6: correction and clamp
  logic [QW-1:0]   rem;
  logic [VW:0]     val;
  logic [VW-1:0]   out_d, out_q;

  always_comb begin
    if (cell_i.zero) begin
      ang_d = '0;
    end else if (cell_i.z < 0) begin
      ang_d = AW'(cell_i.z + $signed(ZW'(FULL_TURN)));
    end else if (cell_i.z >= $signed(ZW'(FULL_TURN))) begin
      ang_d = AW'(cell_i.z - $signed(ZW'(FULL_TURN)));
    end else begin
      ang_d = AW'(cell_i.z);
    end
  end

  always_comb begin
    start_adj = (arc_start_i >= CW'(360)) ? arc_start_i - CW'(360) : arc_start_i;
    rel_s = $signed({1'b0, ang_q}) - $signed({1'b0, AW'({start_adj, 10'b0})});
    if (rel_s < 0) begin
      rel_d = AW'(rel_s + $signed({1'b0, FullQ10}));
    end else begin
      rel_d = AW'(rel_s);
    end
  end

  always_comb begin
    past_end = rel_q - SpanQ10;
    to_wrap  = FullQ10 - rel_q;
    if (rel_q > SpanQ10) begin
      clp_d = (past_end < to_wrap) ? SpanQ10 : '0;
    end else begin
      clp_d = rel_q;
    end
  end

  always_comb begin
    num   = NW'(clp_q) * NW'(200) + NW'(SpanQ10);
    quo_d = QW'(num >> 11);
  end

  always_comb begin
    prod  = (QW+RSH+1)'(quo_q) * (QW+RSH+1)'(Recip);
    est_d = prod[RSH +: VW];
  end

  always_comb begin
    rem = quo2_q - QW'(est_q) * QW'(SpanDeg);
    val = (rem >= QW'(SpanDeg)) ? {1'b0, est_q} + 1'b1 : {1'b0, est_q};
    out_d = (val > {1'b0, MaxVal}) ? MaxVal : val[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], cell_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q  <= ang_d;
    rel_q  <= rel_d;
    clp_q  <= clp_d;
    quo_q  <= quo_d;
    quo2_q <= quo_q;
    est_q  <= est_d;
    out_q  <= out_d;
  end

  assign vld_o        = vld_q[5];
  assign knob_value_o = out_q;

endmodule

/* rtl/touch_angle_to_knob_value_top.sv */
// top level of the touch angle to knob value block
// depends on tkv_pkg, tkv_prep, tkv_cordic_cell, tkv_post and the macros header
//
// usage:
//   a touch point (touch_x_i, touch_y_i) is transferred at a rising edge with
//   start high and busy low. busy never rises, so one point can be sent every
//   cycle. each point yields one knob_value_o, shown for one cycle with done_o.
//   a point passes a registered front cell, one registered cell per cordic
//   iteration, and registers for angle wrap, arc mapping, clamp and
//   reciprocal scaling before its result is taken.
//   throughput is one point per cycle, set by the row of cordic cells in
//   which every iteration has its own register.
//   the receiver cannot stall: done_o and knob_value_o last one cycle only.
//   configuration (centre x, centre y, arc start) is written through the
//   cfg channel, always ready; the user must write it only while no point is
//   in flight (not enforced by the block). reset clears the pipeline valid
//   bits and loads the centre at 240, 240 and the arc start at 135 degrees.
`include "touch_angle_to_knob_value_top_macros.svh"

module touch_angle_to_knob_value_top #(
  parameter int unsigned CORDIC_STAGES = tkv_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned ARC_SPAN_DEG  = tkv_pkg::ARC_SPAN_DEG_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // point channel
  input  logic                   start,
  output logic                   busy,
  input  logic [tkv_pkg::CW-1:0] touch_x_i,
  input  logic [tkv_pkg::CW-1:0] touch_y_i,
  // result channel
  output logic                   done_o,
  output logic [tkv_pkg::VW-1:0] knob_value_o,
  // configuration channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_index_i,
  input  logic [tkv_pkg::CW-1:0] cfg_data_i
);
  import tkv_pkg::*;

  localparam int unsigned LATENCY = CORDIC_STAGES + 7;

  logic [CW-1:0] center_x_q, center_y_q, arc_start_q;
  logic          in_xfer;
  cordic_t       chain [CORDIC_STAGES+1];

  // the pipeline takes a point every cycle
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign in_xfer     = start && !busy;

  // configuration registers, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q  <= CENTER_X_RST;
      center_y_q  <= CENTER_Y_RST;
      arc_start_q <= ARC_START_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CENTER_X:  center_x_q  <= cfg_data_i;
        REG_CENTER_Y:  center_y_q  <= cfg_data_i;
        REG_ARC_START: arc_start_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // offset from the centre and fold into the right half plane
  tkv_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (in_xfer),
    .touch_x_i  (touch_x_i),
    .touch_y_i  (touch_y_i),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .cell_o     (chain[0])
  );

  // row of cordic cells, each one iteration wide
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    tkv_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cell_i (chain[i]),
      .cell_o (chain[i+1])
    );
  end

  // angle to percent along the arc
  tkv_post #(
    .ARC_SPAN_DEG (ARC_SPAN_DEG)
  ) u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_i       (chain[CORDIC_STAGES]),
    .arc_start_i  (arc_start_q),
    .vld_o        (done_o),
    .knob_value_o (knob_value_o)
  );

  // every transfer comes out after the fixed latency
  `TKV_ASSERT_DELAY(a_latency, clk_i, rst_ni, in_xfer, LATENCY, done_o, "result missing")
  // no result without a transfer the latency before
  `TKV_ASSERT_IMPL(a_no_spurious, clk_i, rst_ni, done_o, $past(in_xfer, LATENCY), "spurious result")
  // value stays on the arc scale
  `TKV_ASSERT_IMPL(a_range, clk_i, rst_ni, done_o, knob_value_o <= VW'(100), "value above 100")

endmodule

/* dv/tb_top.sv */
// self-checking testbench for touch_angle_to_knob_value_top: directed table then random points
// predicts untyped points with an in-bench cordic model; depends on tkv_pkg and the rtl top
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tkv_pkg::*;

  // pipeline depth from transfer edge to result edge
  localparam int LAT       = CORDIC_STAGES_DEF + 7;
  localparam int SPAN_Q10  = ARC_SPAN_DEG_DEF * DEG_ONE;
  localparam int TURN_Q10  = FULL_TURN;
  localparam int HALF_Q10  = HALF_TURN;
  localparam int N_DIR     = 22;
  localparam int N_PHASES  = 12;
  localparam int PHASE_PTS = 40;

  // atan(2^-i) in q.10 degrees, own copy for the predictor
  localparam int ANG_STEP [TABLE_LEN] = '{
    46080, 27203, 14373, 7296, 3662, 1833, 917, 458,
    229, 115, 57, 29, 14, 7, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct packed {
    logic [CW-1:0] tx;
    logic [CW-1:0] ty;
    logic          typed;  // expected value written into the row
    logic [VW-1:0] val;
  } dir_row_t;

  typedef struct packed {
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [CW-1:0] arc;
  } knob_cfg_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [CW-1:0] touch_x_i = '0;
  logic [CW-1:0] touch_y_i = '0;
  logic          done_o;
  logic [VW-1:0] knob_value_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  reg_idx_e      cfg_index_i = REG_CENTER_X;
  logic [CW-1:0] cfg_data_i = '0;

  // bench copy of the configuration registers
  logic [CW-1:0] knob_cx  = CENTER_X_RST;
  logic [CW-1:0] knob_cy  = CENTER_Y_RST;
  logic [CW-1:0] knob_arc = ARC_START_RST;

  logic [VW-1:0] knob_exp_q [$];
  int            mismatch_cnt = 0;
  bit            burst_mode = 1'b0;

  touch_angle_to_knob_value_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .touch_x_i    (touch_x_i),
    .touch_y_i    (touch_y_i),
    .done_o       (done_o),
    .knob_value_o (knob_value_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatch_cnt++;
    $display("%0t knob check: %s (expected %0d, got %0d)", $realtime, what, want, got);
  endtask

  // knob value for one touch point under the current bench configuration
  function automatic logic [VW-1:0] knob_of(input logic [CW-1:0] tx, input logic [CW-1:0] ty);
    int     dx, dy, x, y, z, xs, ys, ang, rel, arc_deg;
    longint v;
    dx = int'(tx) - int'(knob_cx);
    dy = int'(ty) - int'(knob_cy);
    arc_deg = int'(knob_arc);
    if (arc_deg >= 360) arc_deg -= 360;
    if (dx == 0 && dy == 0) begin
      ang = 0;
    end else begin
      x = dx * (1 << PRE_SHIFT);
      y = dy * (1 << PRE_SHIFT);
      z = 0;
      // left half plane: rotate by 180 first
      if (x < 0) begin
        x = -x;
        y = -y;
        z = HALF_Q10;
      end
      for (int i = 0; i < CORDIC_STAGES_DEF && i < TABLE_LEN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ANG_STEP[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ANG_STEP[i];
        end
      end
      if (z < 0) z += TURN_Q10;
      else if (z >= TURN_Q10) z -= TURN_Q10;
      ang = z;
    end
    rel = ang - arc_deg * DEG_ONE;
    if (rel < 0) rel += TURN_Q10;
    // dead gap: snap to the strictly nearer arc end, ties go to the start
    if (rel > SPAN_Q10) rel = ((rel - SPAN_Q10) < (TURN_Q10 - rel)) ? SPAN_Q10 : 0;
    v = (longint'(rel) * 200 + SPAN_Q10) / (longint'(SPAN_Q10) * 2);
    if (v < 0) v = 0;
    if (v > 100) v = 100;
    return v[VW-1:0];
  endfunction

  function automatic logic [CW-1:0] clip9(input int v);
    if (v < 0) return '0;
    if (v > 511) return '1;
    return v[CW-1:0];
  endfunction

  // short gaps and back to back about equally often, a few long ones; all back to back in burst mode
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // one point transfer; start stays high when the next point follows at once
  task automatic send_point(input logic [CW-1:0] tx, input logic [CW-1:0] ty,
                            input logic typed, input logic [VW-1:0] tval, input int gap);
    start     <= 1'b1;
    touch_x_i <= tx;
    touch_y_i <= ty;
    do @(posedge clk_i); while (busy);
    knob_exp_q.push_back(typed ? tval : knob_of(tx, ty));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender holds off until the pipeline has delivered everything
  task automatic hold_until_empty();
    if (start) start <= 1'b0;
    @(posedge clk_i);
    while (knob_exp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_xfer(input reg_idx_e idx, input logic [CW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_CENTER_X:  knob_cx  = data;
      REG_CENTER_Y:  knob_cy  = data;
      REG_ARC_START: knob_arc = data;
      default: ;
    endcase
  endtask

  // rewrite all three registers, only with the pipeline empty
  task automatic load_cfg(input knob_cfg_t c);
    hold_until_empty();
    repeat (LAT) @(posedge clk_i);
    cfg_xfer(REG_CENTER_X, c.cx);
    cfg_xfer(REG_CENTER_Y, c.cy);
    cfg_xfer(REG_ARC_START, c.arc);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic pick_point(output logic [CW-1:0] tx, output logic [CW-1:0] ty);
    int kind, k, sx, sy;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      tx = CW'($urandom_range(0, 479));
      ty = CW'($urandom_range(0, 479));
    end else if (kind < 75) begin
      // full 9 bit range, past the panel edge
      tx = CW'($urandom_range(0, 511));
      ty = CW'($urandom_range(0, 511));
    end else if (kind < 90) begin
      // a few pixels around the centre
      tx = clip9(int'(knob_cx) + int'($urandom_range(0, 8)) - 4);
      ty = clip9(int'(knob_cy) + int'($urandom_range(0, 8)) - 4);
    end else begin
      // on an axis or a diagonal through the centre
      k  = $urandom_range(1, 240);
      sx = int'($urandom_range(0, 2)) - 1;
      sy = int'($urandom_range(0, 2)) - 1;
      tx = clip9(int'(knob_cx) + sx * k);
      ty = clip9(int'(knob_cy) + sy * k);
    end
  endtask

  // result monitor: each done_o pulse is matched against the oldest expectation
  always @(posedge clk_i) begin : knob_mon
    logic [VW-1:0] want;
    if (rst_ni && done_o) begin
      if (knob_exp_q.size() == 0) begin
        note_mismatch("result with nothing outstanding", -1, int'(knob_value_o));
      end else begin
        want = knob_exp_q.pop_front();
        if (knob_value_o !== want) note_mismatch("knob_value", int'(want), int'(knob_value_o));
      end
    end
  end

  initial begin : stim
    dir_row_t  dir_tbl [N_DIR];
    knob_cfg_t phase_cfg [N_PHASES];
    logic [CW-1:0] px, py;
    int        n;

    // reset config: centre 240,240, arc start 135
    dir_tbl = '{
      '{9'd240, 9'd240, 1'b1, 7'd83},   // touch on the centre
      '{9'd1,   9'd479, 1'b1, 7'd0},    // arc start direction
      '{9'd479, 9'd479, 1'b1, 7'd100},  // arc end direction
      '{9'd240, 9'd0,   1'b1, 7'd50},   // straight up, mid arc
      '{9'd240, 9'd479, 1'b0, 7'd0},    // straight down, middle of the dead gap
      '{9'd0,   9'd240, 1'b0, 7'd0},
      '{9'd479, 9'd240, 1'b0, 7'd0},
      '{9'd0,   9'd0,   1'b0, 7'd0},
      '{9'd511, 9'd511, 1'b0, 7'd0},
      '{9'd511, 9'd0,   1'b0, 7'd0},
      '{9'd0,   9'd511, 1'b0, 7'd0},
      '{9'd479, 9'd0,   1'b0, 7'd0},
      '{9'd241, 9'd240, 1'b0, 7'd0},
      '{9'd239, 9'd240, 1'b0, 7'd0},
      '{9'd240, 9'd241, 1'b0, 7'd0},
      '{9'd240, 9'd239, 1'b0, 7'd0},
      '{9'd479, 9'd378, 1'b0, 7'd0},    // on the arc, short of its end
      '{9'd200, 9'd479, 1'b0, 7'd0},    // dead gap, nearer the arc start
      '{9'd170, 9'd341, 1'b0, 7'd0},
      '{9'd341, 9'd170, 1'b0, 7'd0},
      '{9'd256, 9'd256, 1'b0, 7'd0},
      '{9'd255, 9'd255, 1'b0, 7'd0}
    };

    // extremes first, then the reset setting, then random settings
    phase_cfg[0] = '{9'd0,   9'd0,   9'd0};
    phase_cfg[1] = '{9'd479, 9'd479, 9'd359};
    phase_cfg[2] = '{9'd511, 9'd511, 9'd360};  // arc start of exactly one turn, folded to 0
    phase_cfg[3] = '{9'd0,   9'd479, 9'd511};
    phase_cfg[4] = '{9'd479, 9'd0,   9'd180};
    phase_cfg[5] = '{CENTER_X_RST, CENTER_Y_RST, ARC_START_RST};
    for (int p = 6; p < N_PHASES; p++) begin
      phase_cfg[p].cx  = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                     : 9'($urandom_range(0, 479));
      phase_cfg[p].cy  = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                     : 9'($urandom_range(0, 479));
      phase_cfg[p].arc = 9'($urandom_range(0, 511));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows under the reset configuration
    for (int r = 0; r < N_DIR; r++)
      send_point(dir_tbl[r].tx, dir_tbl[r].ty, dir_tbl[r].typed, dir_tbl[r].val, pick_gap());

    for (int p = 0; p < N_PHASES; p++) begin
      load_cfg(phase_cfg[p]);
      burst_mode = ($urandom_range(0, 3) == 0);
      // centre and two opposite corners under every setting
      send_point(knob_cx, knob_cy, 1'b0, '0, pick_gap());
      send_point('0, '0, 1'b0, '0, pick_gap());
      send_point('1, '1, 1'b0, '0, pick_gap());
      for (int i = 0; i < PHASE_PTS; i++) begin
        pick_point(px, py);
        send_point(px, py, 1'b0, '0, pick_gap());
        if ($urandom_range(0, 49) == 0) hold_until_empty();
      end
    end

    // drain, bounded, then let any stray result show up
    if (start) start <= 1'b0;
    n = 0;
    do begin
      @(posedge clk_i);
      n++;
    end while (knob_exp_q.size() != 0 && n < 4 * LAT);
    repeat (LAT + 4) @(posedge clk_i);
    if (knob_exp_q.size() != 0)
      note_mismatch("results never delivered", 0, knob_exp_q.size());

    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
